[rtl/core/tsn_pkg.sv]
// ----------------------------------------------------------------------------
// tsn_pkg
// Shared types and constants of the taxel spiking neuron: configuration
// layout, per-taxel state word, pipeline enables and saturation helper.
// ----------------------------------------------------------------------------
package tsn_pkg;

    localparam int IDX_W    = 4;
    localparam int SAMPLE_W = 12;
    localparam int Q_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECOVERY_RATE        = 3'd0,
        CFG_RECOVERY_SENSITIVITY = 3'd1,
        CFG_RESET_POTENTIAL      = 3'd2,
        CFG_RECOVERY_JUMP        = 3'd3,
        CFG_SPIKE_THRESHOLD      = 3'd4,
        CFG_CURRENT_SCALE        = 3'd5,
        CFG_TIME_STEP            = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        rate;       // a, Q0.16
        logic [15:0]        sens;       // b, Q0.16
        logic signed [23:0] reset_pot;  // Q8.16
        logic [21:0]        jump;       // Q6.16
        logic [23:0]        thresh;     // Q8.16
        logic [15:0]        scale;      // Q16.16 per count
        logic [2:0]         tstep;
    } t_cfg;

    localparam logic [15:0]        RATE_RST      = 16'd1311;
    localparam logic [15:0]        SENS_RST      = 16'd13107;
    localparam logic signed [23:0] RESET_POT_RST = -24'sd4259840;
    localparam logic [21:0]        JUMP_RST      = 22'd524288;
    localparam logic [23:0]        THRESH_RST    = 24'd1966080;
    localparam logic [15:0]        SCALE_RST     = 16'd293;
    localparam logic [2:0]         TSTEP_RST     = 3'd2;

    // per-taxel state word
    typedef struct packed {
        logic [SAMPLE_W-1:0]   last;
        logic signed [Q_W-1:0] v;
        logic signed [Q_W-1:0] u;
    } t_state;

    localparam logic signed [Q_W-1:0] MEMBRANE_INIT = -32'sd1966080;
    localparam t_state STATE_INIT = '{last: 12'd4095, v: MEMBRANE_INIT, u: 32'sd0};

    // 0.04 in Q0.16, and 140 in Q16.16
    localparam logic [11:0]        QUAD_COEF  = 12'd2621;
    localparam logic signed [45:0] CONST_TERM = 46'sd9175040;

    // stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    typedef struct packed {
        logic                  clip;
        logic signed [Q_W-1:0] val;
    } t_sat;

    localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

    function automatic t_sat sat32(input logic signed [49:0] x);
        t_sat r;
        if (x > S32_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = $signed(x[31:0]);
        end
        return r;
    endfunction

endpackage

[rtl/core/tsn_if.sv]
// ----------------------------------------------------------------------------
// tsn_if
// Valid/ready channels of the taxel spiking neuron: sample in, result out
// and configuration write.
// ----------------------------------------------------------------------------
interface tsn_in_if;
    logic                           valid;
    logic                           ready;
    logic [tsn_pkg::IDX_W-1:0]      taxel_index;
    logic [tsn_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, taxel_index, sample, input ready);
    modport sink   (input valid, taxel_index, sample, output ready);
endinterface

interface tsn_res_if;
    logic                           valid;
    logic                           ready;
    logic [tsn_pkg::IDX_W-1:0]      taxel_out;
    logic                           spike;
    logic signed [tsn_pkg::Q_W-1:0] potential;
    logic                           saturated;

    modport source (output valid, taxel_out, spike, potential, saturated, input ready);
    modport sink   (input valid, taxel_out, spike, potential, saturated, output ready);
endinterface

interface tsn_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tsn_pkg::CFG_IDX_W-1:0]    index;
    logic [tsn_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/taxel_spiking_neuron.sv]
// ----------------------------------------------------------------------------
// taxel_spiking_neuron
// One Izhikevich neuron per taxel, stepped once per tactile sample.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : valid/ready words of {taxel_index, sample}.
//   o_res  : valid/ready words of {taxel_out, spike, potential, saturated},
//            one per sample whose index is below TAXEL_COUNT; other indices
//            are taken and dropped without a result.
//   i_cfg  : valid/ready register writes {index, data}; always ready. Write
//            only while no sample is in flight.
// Path: stages 1 to 5, then the output register that drives o_res.valid.
// Throughput: one word per cycle across different taxels while o_res.ready
//   is high. A sample whose taxel is still in one of the five arithmetic
//   stages is held off until that taxel's state has been written back, so
//   a repeat of one taxel waits for the earlier word to leave stage 5; the
//   state memory read/write loop sets this.
// Reset: synchronous, active low; empties the pipeline, restores register
//   defaults and marks every taxel's state as initial (no clearing pass).
// Stall: o_res holds its word while ready is low; earlier stages keep
//   filling until full, then i_in.ready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module taxel_spiking_neuron #(
    parameter int TAXEL_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsn_in_if.sink      i_in,
    tsn_res_if.source   o_res,
    tsn_cfg_if.sink     i_cfg
);

    localparam int DEPTH = (TAXEL_COUNT < 16) ? TAXEL_COUNT : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] COUNT_L = 9'(TAXEL_COUNT);

    tsn_pkg::t_cfg     c_cfg;
    tsn_pkg::t_state   c_rd, c_wb;
    tsn_pkg::t_pipe_en c_en;
    logic              c_spike, c_sat;

    logic [5:1] r_vld, r_inr;
    logic [3:0] r_idx [1:5];
    logic [6:1] c_ok;
    logic       c_hazard, c_accept, c_in_range, c_wr;

    logic                  r_vo;
    logic [3:0]            r_o_idx;
    logic                  r_o_spike, r_o_sat;
    logic signed [31:0]    r_o_pot;

    tsn_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (c_cfg)
    );

    // stage k may load when empty or when its word moves on
    always_comb begin
        c_ok[6] = !r_vo || o_res.ready;
        c_ok[5] = !r_vld[5] || c_ok[6];
        c_ok[4] = !r_vld[4] || c_ok[5];
        c_ok[3] = !r_vld[3] || c_ok[4];
        c_ok[2] = !r_vld[2] || c_ok[3];
        c_ok[1] = !r_vld[1] || c_ok[2];
    end

    // same taxel still in flight: its state is not written back yet
    always_comb begin
        c_hazard = 1'b0;
        for (int k = 1; k <= 5; k++) begin
            if (r_vld[k] && r_inr[k] && (r_idx[k] == i_in.taxel_index)) begin
                c_hazard = 1'b1;
            end
        end
    end

    assign c_in_range  = {5'd0, i_in.taxel_index} < COUNT_L;
    assign i_in.ready  = c_ok[1] && !c_hazard;
    assign c_accept    = i_in.valid && i_in.ready;
    assign c_wr        = c_ok[6] && r_vld[5] && r_inr[5];

    assign c_en.s1 = c_ok[1];
    assign c_en.s2 = c_ok[2];
    assign c_en.s3 = c_ok[3];
    assign c_en.s4 = c_ok[4];
    assign c_en.s5 = c_ok[5];

    tsn_state_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (c_ok[1]),
        .i_rd_addr (i_in.taxel_index[AW-1:0]),
        .o_rd      (c_rd),
        .i_wr_en   (c_wr),
        .i_wr_addr (r_idx[5][AW-1:0]),
        .i_wr      (c_wb)
    );

    tsn_datapath u_dp (
        .i_clk    (i_clk),
        .i_en     (c_en),
        .i_cfg    (c_cfg),
        .i_sample (i_in.sample),
        .i_st     (c_rd),
        .o_wb     (c_wb),
        .o_spike  (c_spike),
        .o_sat    (c_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_vo  <= 1'b0;
        end else begin
            if (c_ok[1]) begin
                r_vld[1] <= c_accept;
            end
            for (int k = 2; k <= 5; k++) begin
                if (c_ok[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (c_ok[6]) begin
                r_vo <= r_vld[5] && r_inr[5];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ok[1]) begin
            r_idx[1] <= i_in.taxel_index;
            r_inr[1] <= c_in_range;
        end
        for (int k = 2; k <= 5; k++) begin
            if (c_ok[k]) begin
                r_idx[k] <= r_idx[k-1];
                r_inr[k] <= r_inr[k-1];
            end
        end
        if (c_wr) begin
            r_o_idx   <= r_idx[5];
            r_o_spike <= c_spike;
            r_o_pot   <= c_wb.v;
            r_o_sat   <= c_sat;
        end
    end

    assign o_res.valid     = r_vo;
    assign o_res.taxel_out = r_o_idx;
    assign o_res.spike     = r_o_spike;
    assign o_res.potential = r_o_pot;
    assign o_res.saturated = r_o_sat;

    // two in-flight words of one taxel would read stale state
    a_no_dup_12: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_inr[1] && r_vld[2] && r_inr[2]) |-> (r_idx[1] != r_idx[2]))
        else $error("same taxel in stages 1 and 2");

    a_no_dup_15: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_inr[1] && r_vld[5] && r_inr[5]) |-> (r_idx[1] != r_idx[5]))
        else $error("same taxel in stages 1 and 5");

    a_res_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ({5'd0, o_res.taxel_out} < COUNT_L))
        else $error("result for a dropped taxel index");

    a_spike_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.spike) |->
        (o_res.potential == {{8{c_cfg.reset_pot[23]}}, c_cfg.reset_pot}))
        else $error("spike without potential reset");

    a_below_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.spike) |->
        ($signed({o_res.potential[31], o_res.potential}) < $signed({9'd0, c_cfg.thresh})))
        else $error("potential at threshold without spike");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

[rtl/core/tsn_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tsn_cfg_regs
// Configuration register file; one word written per handshake.
// ----------------------------------------------------------------------------
module tsn_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tsn_cfg_if.sink         i_cfg,
    output tsn_pkg::t_cfg   o_cfg
);

    tsn_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate      <= tsn_pkg::RATE_RST;
            r_cfg.sens      <= tsn_pkg::SENS_RST;
            r_cfg.reset_pot <= tsn_pkg::RESET_POT_RST;
            r_cfg.jump      <= tsn_pkg::JUMP_RST;
            r_cfg.thresh    <= tsn_pkg::THRESH_RST;
            r_cfg.scale     <= tsn_pkg::SCALE_RST;
            r_cfg.tstep     <= tsn_pkg::TSTEP_RST;
        end else if (i_cfg.valid) begin
            unique case (tsn_pkg::t_cfg_idx'(i_cfg.index))
                tsn_pkg::CFG_RECOVERY_RATE:        r_cfg.rate      <= i_cfg.data[15:0];
                tsn_pkg::CFG_RECOVERY_SENSITIVITY: r_cfg.sens      <= i_cfg.data[15:0];
                tsn_pkg::CFG_RESET_POTENTIAL:      r_cfg.reset_pot <= $signed(i_cfg.data[23:0]);
                tsn_pkg::CFG_RECOVERY_JUMP:        r_cfg.jump      <= i_cfg.data[21:0];
                tsn_pkg::CFG_SPIKE_THRESHOLD:      r_cfg.thresh    <= i_cfg.data[23:0];
                tsn_pkg::CFG_CURRENT_SCALE:        r_cfg.scale     <= i_cfg.data[15:0];
                tsn_pkg::CFG_TIME_STEP:            r_cfg.tstep     <= i_cfg.data[2:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/tsn_state_mem.sv]
// ----------------------------------------------------------------------------
// tsn_state_mem
// Per-taxel state memory: one write and one registered read per cycle.
// Entries never written read back as the reset state.
// ----------------------------------------------------------------------------
module tsn_state_mem #(
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output tsn_pkg::t_state o_rd,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  tsn_pkg::t_state i_wr
);

    tsn_pkg::t_state r_mem [DEPTH];
    tsn_pkg::t_state r_rd;
    logic [DEPTH-1:0] r_init;
    logic             r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_init[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_init[i_rd_addr];
            end
        end
    end

    assign o_rd = r_rd_init ? r_rd : tsn_pkg::STATE_INIT;

endmodule

[rtl/core/tsn_datapath.sv]
// ----------------------------------------------------------------------------
// tsn_datapath
// Five-stage Euler step: products, quadratic term, derivatives, saturated
// update, then spike test and reset on the way out.
// ----------------------------------------------------------------------------
module tsn_datapath (
    input  logic                           i_clk,
    input  tsn_pkg::t_pipe_en              i_en,
    input  tsn_pkg::t_cfg                  i_cfg,
    input  logic [tsn_pkg::SAMPLE_W-1:0]   i_sample,
    input  tsn_pkg::t_state                i_st,
    output tsn_pkg::t_state                o_wb,
    output logic                           o_spike,
    output logic                           o_sat
);

    // stage 1: sample (state arrives from the memory read register)
    logic [11:0]        r_s1_sample;
    // stage 2
    logic [11:0]        r_s2_sample;
    logic signed [29:0] r_s2_cur;
    logic [63:0]        r_s2_sq;
    logic signed [48:0] r_s2_bvp;
    logic signed [31:0] r_s2_v, r_s2_u;
    // stage 3
    logic [11:0]        r_s3_sample;
    logic signed [29:0] r_s3_cur;
    logic [43:0]        r_s3_quad;
    logic signed [33:0] r_s3_diff;
    logic signed [31:0] r_s3_v, r_s3_u;
    // stage 4
    logic [11:0]        r_s4_sample;
    logic signed [45:0] r_s4_dv;
    logic signed [34:0] r_s4_du;
    logic signed [31:0] r_s4_v, r_s4_u;
    // stage 5
    logic [11:0]        r_s5_sample;
    logic signed [31:0] r_s5_vn, r_s5_un;
    logic               r_s5_clip;

    logic signed [12:0] c_dsamp;
    logic signed [29:0] c_cur;
    logic [31:0]        c_mag;
    logic [63:0]        c_sq;
    logic signed [48:0] c_bvp;
    logic [59:0]        c_quadp;
    logic signed [32:0] c_bv;
    logic signed [33:0] c_diff;
    logic signed [45:0] c_dv;
    logic signed [50:0] c_dup;
    logic signed [49:0] c_vn, c_un, c_uj;
    logic signed [3:0]  c_t;
    tsn_pkg::t_sat      c_vsat, c_usat, c_jsat;
    logic signed [32:0] c_thresh;

    // stage 2 logic: current, |v|^2, b*v
    always_comb begin
        c_dsamp = $signed({1'b0, r_s1_sample}) - $signed({1'b0, i_st.last});
        c_cur   = $signed({1'b0, i_cfg.scale}) * c_dsamp;
        c_mag   = i_st.v[31] ? (32'd0 - i_st.v) : i_st.v;
        c_sq    = c_mag * c_mag;
        c_bvp   = $signed({1'b0, i_cfg.sens}) * i_st.v;
    end

    // stage 3 logic: 0.04 v^2 and b*v - u
    always_comb begin
        c_quadp = r_s2_sq[63:16] * tsn_pkg::QUAD_COEF;
        c_bv    = $signed(r_s2_bvp[48:16]);
        c_diff  = c_bv - r_s2_u;
    end

    // stage 4 logic: dv and du
    always_comb begin
        c_dv  = $signed({2'b00, r_s3_quad}) + 46'sd5 * r_s3_v + tsn_pkg::CONST_TERM
                - r_s3_u + r_s3_cur;
        c_dup = $signed({1'b0, i_cfg.rate}) * r_s3_diff;
    end

    // stage 5 logic: Euler update with clipping
    always_comb begin
        c_t    = $signed({1'b0, i_cfg.tstep});
        c_vn   = r_s4_v + c_t * r_s4_dv;
        c_un   = r_s4_u + c_t * r_s4_du;
        c_vsat = tsn_pkg::sat32(c_vn);
        c_usat = tsn_pkg::sat32(c_un);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_sample <= i_sample;
        end
        if (i_en.s2) begin
            r_s2_sample <= r_s1_sample;
            r_s2_cur    <= c_cur;
            r_s2_sq     <= c_sq;
            r_s2_bvp    <= c_bvp;
            r_s2_v      <= i_st.v;
            r_s2_u      <= i_st.u;
        end
        if (i_en.s3) begin
            r_s3_sample <= r_s2_sample;
            r_s3_cur    <= r_s2_cur;
            r_s3_quad   <= c_quadp[59:16];
            r_s3_diff   <= c_diff;
            r_s3_v      <= r_s2_v;
            r_s3_u      <= r_s2_u;
        end
        if (i_en.s4) begin
            r_s4_sample <= r_s3_sample;
            r_s4_dv     <= c_dv;
            r_s4_du     <= $signed(c_dup[50:16]);
            r_s4_v      <= r_s3_v;
            r_s4_u      <= r_s3_u;
        end
        if (i_en.s5) begin
            r_s5_sample <= r_s4_sample;
            r_s5_vn     <= c_vsat.val;
            r_s5_un     <= c_usat.val;
            r_s5_clip   <= c_vsat.clip | c_usat.clip;
        end
    end

    // spike test, reset and recovery jump
    always_comb begin
        c_thresh = $signed({9'd0, i_cfg.thresh});
        o_spike  = $signed({r_s5_vn[31], r_s5_vn}) >= c_thresh;
        c_uj     = r_s5_un + $signed({28'd0, i_cfg.jump});
        c_jsat   = tsn_pkg::sat32(c_uj);
        o_wb.last = r_s5_sample;
        if (o_spike) begin
            o_wb.v = {{8{i_cfg.reset_pot[23]}}, i_cfg.reset_pot};
            o_wb.u = c_jsat.val;
            o_sat  = r_s5_clip | c_jsat.clip;
        end else begin
            o_wb.v = r_s5_vn;
            o_wb.u = r_s5_un;
            o_sat  = r_s5_clip;
        end
    end

endmodule

[dv/taxel_spiking_neuron_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taxel_spiking_neuron_test
// Self-checking bench for the per-taxel Izhikevich neuron. Drives sample
// words through several register settings (field extremes, zero and wide
// step widths, saturating gains) with random gaps on both sides, and checks
// every result word against a bit-exact fixed-point model of the neuron.
// ----------------------------------------------------------------------------
module taxel_spiking_neuron_test;

    localparam int TAXELS      = 16;
    localparam int SETTLE_CYC  = 12;      // pipeline latency plus margin
    localparam int HOLD_CYC    = 200;     // long result back-pressure
    localparam int TIMEOUT_NS  = 2_000_000;
    localparam longint Q_MAX   = 64'sd2147483647;
    localparam longint Q_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic [tsn_pkg::IDX_W-1:0]      taxel;
        logic                           spike;
        logic signed [tsn_pkg::Q_W-1:0] potential;
        logic                           saturated;
    } t_neuron_result;

    // ------------------------------------------------------------------------
    // Neuron model and result scoreboard
    // ------------------------------------------------------------------------
    class t_neuron_scoreboard;
        logic [15:0]        rate;
        logic [15:0]        sens;
        logic signed [23:0] reset_pot;
        logic [21:0]        jump;
        logic [23:0]        thresh;
        logic [15:0]        scale;
        logic [2:0]         tstep;

        logic [11:0]        prev_sample [TAXELS];
        logic signed [31:0] membrane_v  [TAXELS];
        logic signed [31:0] recovery_u  [TAXELS];

        t_neuron_result     expected_q [$];
        int                 failures;
        int                 checked;
        int                 spikes;
        int                 clips;

        function new();
            rate      = 16'd1311;
            sens      = 16'd13107;
            reset_pot = -24'sd4259840;
            jump      = 22'd524288;
            thresh    = 24'd1966080;
            scale     = 16'd293;
            tstep     = 3'd2;
            for (int i = 0; i < TAXELS; i++) begin
                prev_sample[i] = 12'd4095;
                membrane_v[i]  = -32'sd1966080;
                recovery_u[i]  = 32'sd0;
            end
        endfunction

        function void write_reg(tsn_pkg::t_cfg_idx idx, logic [23:0] data);
            case (idx)
                tsn_pkg::CFG_RECOVERY_RATE:        rate      = data[15:0];
                tsn_pkg::CFG_RECOVERY_SENSITIVITY: sens      = data[15:0];
                tsn_pkg::CFG_RESET_POTENTIAL:      reset_pot = data;
                tsn_pkg::CFG_RECOVERY_JUMP:        jump      = data[21:0];
                tsn_pkg::CFG_SPIKE_THRESHOLD:      thresh    = data;
                tsn_pkg::CFG_CURRENT_SCALE:        scale     = data[15:0];
                tsn_pkg::CFG_TIME_STEP:            tstep     = data[2:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint x, ref bit clipped);
            if (x > Q_MAX) begin
                clipped = 1'b1;
                return Q_MAX;
            end
            if (x < Q_MIN) begin
                clipped = 1'b1;
                return Q_MIN;
            end
            return x;
        endfunction

        // one Euler step of the taxel's neuron; queues the expected word
        function void note_sample(logic [3:0] taxel, logic [11:0] smp);
            longint          v, u, drive, quad, dv, bv, du, vn, un;
            longint unsigned mag, sq;
            bit              clipped;
            t_neuron_result  r;
            clipped = 1'b0;

            drive = longint'(scale) * (longint'(smp) - longint'(prev_sample[taxel]));
            prev_sample[taxel] = smp;
            v = membrane_v[taxel];
            u = recovery_u[taxel];

            mag  = (v < 0) ? longint'(-v) : longint'(v);
            sq   = (mag * mag) >> 16;
            quad = longint'((sq * 64'd2621) >> 16);
            dv   = quad + 5 * v + 64'sd9175040 - u + drive;
            bv   = (longint'(sens) * v) >>> 16;
            du   = (longint'(rate) * (bv - u)) >>> 16;

            vn = clip32(v + longint'(tstep) * dv, clipped);
            un = clip32(u + longint'(tstep) * du, clipped);

            r.spike = (vn >= longint'(thresh));
            if (r.spike) begin
                vn = longint'(reset_pot);
                un = clip32(un + longint'(jump), clipped);
                spikes++;
            end
            membrane_v[taxel] = vn[31:0];
            recovery_u[taxel] = un[31:0];
            if (clipped)
                clips++;

            r.taxel     = taxel;
            r.potential = vn[31:0];
            r.saturated = clipped;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_neuron_result got);
            t_neuron_result want;
            checked++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result word: taxel %0d spike %0b pot %0d sat %0b",
                             got.taxel, got.spike, got.potential, got.saturated);
                return;
            end
            want = expected_q.pop_front();
            if (got.taxel !== want.taxel || got.spike !== want.spike ||
                got.potential !== want.potential || got.saturated !== want.saturated) begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR: result %0d: expected taxel %0d spike %0b pot %0d sat %0b,",
                              " got taxel %0d spike %0b pot %0d sat %0b"},
                             checked, want.taxel, want.spike, want.potential, want.saturated,
                             got.taxel, got.spike, got.potential, got.saturated);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    tsn_in_if  in_if ();
    tsn_res_if res_if ();
    tsn_cfg_if cfg_if ();

    taxel_spiking_neuron #(
        .TAXEL_COUNT (TAXELS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_neuron_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int words_sent;
    int settings;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: run did not complete in time, %0d results outstanding",
                 sb.outstanding());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random ready, occasional long hold-off, checking monitor
    // ------------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
            end
            res_if.ready <= rx_idle ? ($urandom_range(99) >= 11) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_neuron_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.taxel_out, res_if.spike, res_if.potential, res_if.saturated};
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    task automatic send_sample(logic [3:0] taxel, logic [11:0] smp);
        int gap;
        gap = (tx_idle && $urandom_range(99) < 11) ? 1 : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.taxel_index <= taxel;
        in_if.sample      <= smp;
        forever begin
            @(posedge i_clk);
            if (in_if.ready)
                break;
        end
        sb.note_sample(taxel, smp);
        words_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // half of the samples at a rail (0 or 4095) so the neurons actually fire
    task automatic random_burst(int n);
        logic [11:0] smp;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0:       smp = 12'd0;
                1:       smp = 12'd4095;
                default: smp = 12'($urandom_range(4095));
            endcase
            send_sample(4'($urandom_range(TAXELS - 1)), smp);
        end
        end_burst();
    endtask

    task automatic program_reg(tsn_pkg::t_cfg_idx idx, logic [23:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        forever begin
            @(posedge i_clk);
            if (cfg_if.ready)
                break;
        end
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic program_all(logic [15:0] a, logic [15:0] b, logic [23:0] rp,
                               logic [21:0] jmp, logic [23:0] th, logic [15:0] sc,
                               logic [2:0] ts);
        program_reg(tsn_pkg::CFG_RECOVERY_RATE, {8'd0, a});
        program_reg(tsn_pkg::CFG_RECOVERY_SENSITIVITY, {8'd0, b});
        program_reg(tsn_pkg::CFG_RESET_POTENTIAL, rp);
        program_reg(tsn_pkg::CFG_RECOVERY_JUMP, {2'd0, jmp});
        program_reg(tsn_pkg::CFG_SPIKE_THRESHOLD, th);
        program_reg(tsn_pkg::CFG_CURRENT_SCALE, {8'd0, sc});
        program_reg(tsn_pkg::CFG_TIME_STEP, {21'd0, ts});
        settings++;
    endtask

    // wait for every word to come back, then let the pipeline go quiet
    task automatic settle();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.taxel_index = '0;
        in_if.sample      = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = tsn_pkg::CFG_RECOVERY_RATE;
        cfg_if.data       = '0;
        tx_idle           = 1'b1;
        rx_idle           = 1'b1;
        hold_req          = 1'b0;
        settings          = 1;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed words at reset settings: no change, full-scale swings,
        // alternating bit patterns, back-to-back repeats of one taxel
        send_sample(4'd0, 12'd4095);
        send_sample(4'd15, 12'd0);
        send_sample(4'd15, 12'd4095);
        send_sample(4'd1, 12'hAAA);
        send_sample(4'd1, 12'h555);
        send_sample(4'd2, 12'd0);
        send_sample(4'd2, 12'd4095);
        send_sample(4'd2, 12'd4095);
        send_sample(4'd3, 12'd0);
        send_sample(4'd3, 12'd4095);
        send_sample(4'd7, 12'd2048);
        send_sample(4'd8, 12'd1);
        send_sample(4'd8, 12'd4094);
        send_sample(4'd14, 12'd0);
        send_sample(4'd14, 12'd0);
        send_sample(4'd9, 12'd4095);
        end_burst();
        settle();

        // low extremes of every register but the time step; zero threshold fires on any v >= 0
        program_all(16'd0, 16'd0, 24'h800000, 22'd0, 24'd0, 16'd0, 3'd1);
        random_burst(60);
        settle();

        // high extremes of rate, sensitivity, reset potential and current scale
        program_all(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 22'd2097152, 24'd8388608,
                    16'hFFFF, 3'd4);
        random_burst(100);
        settle();

        // zero step width after a run at step four: the Euler update adds nothing, positive potentials keep firing
        program_all(16'd1311, 16'd13107, 24'd327680, 22'd524288, 24'd0, 16'd293, 3'd4);
        random_burst(40);
        settle();
        program_reg(tsn_pkg::CFG_TIME_STEP, 24'd0);
        settings++;
        random_burst(60);
        settle();

        // widest step and full gain: drives both state words into clipping
        program_all(16'd1311, 16'd13107, 24'h800000, 22'd524288, 24'd8388608,
                    16'hFFFF, 3'd7);
        random_burst(100);
        settle();

        // step width five at default tuning, with a long result hold-off
        program_all(16'd1311, 16'd13107, -24'sd4259840, 22'd524288, 24'd1966080,
                    16'd293, 3'd5);
        hold_req = 1'b1;
        random_burst(100);
        settle();

        // step width six, random tuning
        program_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    24'($urandom_range(24'hFFFFFF)),
                    22'($urandom_range(2097152)), 24'($urandom_range(8388608)),
                    16'($urandom_range(65535)), 3'd6);
        random_burst(80);
        settle();

        // default tuning with no idling on either side
        program_all(16'd1311, 16'd13107, -24'sd4259840, 22'd524288, 24'd1966080,
                    16'd293, 3'd2);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_burst(120);
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // fully random settings
        for (int p = 0; p < 3; p++) begin
            program_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        24'($urandom_range(24'hFFFFFF)), 22'($urandom_range(2097152)),
                        24'($urandom_range(8388608)), 16'($urandom_range(65535)),
                        3'($urandom_range(7)));
            random_burst(50);
            settle();
        end

        $display("summary: %0d sample words under %0d register settings, %0d results checked",
                 words_sent, settings, sb.checked);
        $display("summary: %0d spikes and %0d clipped steps predicted, %0d mismatches",
                 sb.spikes, sb.clips, sb.failures);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
